>>> sv/swrt_pkg.sv
// ----------------------------------------------------------------------------
// swrt_pkg
// Shared types and constants of the stop-and-wait retransmission timer.
// ----------------------------------------------------------------------------
package swrt_pkg;

    typedef enum logic [1:0] {
        MODE_ACK_OK     = 2'd0,
        MODE_ACK_REPEAT = 2'd1,
        MODE_TIMEOUT    = 2'd2,
        MODE_BAD_ACK    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ACT_NEXT   = 2'd0,
        ACT_RESEND = 2'd1,
        ACT_DONE   = 2'd2,
        ACT_ABORT  = 2'd3
    } action_t;

    localparam logic REG_TOTAL_FRAGMENTS = 1'b0;
    localparam logic REG_INITIAL_TIMEOUT = 1'b1;

    localparam logic [15:0] TOTAL_RESET   = 16'd1;
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;

    // Item leaving the control and smoothed-estimate stage.
    typedef struct packed {
        action_t     action;
        logic [15:0] frag;
        logic        upd;
        logic        tmo;
        logic [34:0] s8;
        logic [34:0] srtt;
    } s1_t;

    // Item leaving the difference stage.
    typedef struct packed {
        action_t     action;
        logic [15:0] frag;
        logic        upd;
        logic        tmo;
        logic [34:0] srtt;
        logic [33:0] half;
    } s2_t;

    // Item leaving the deviation stage.
    typedef struct packed {
        action_t     action;
        logic [15:0] frag;
        logic        upd;
        logic        tmo;
        logic [34:0] srtt;
        logic [33:0] dev;
    } s3_t;

    typedef struct packed {
        logic finished;
    } status_t;

endpackage

>>> sv/swrt_front.sv
// ----------------------------------------------------------------------------
// swrt_front
// Event decode, fragment bookkeeping and smoothed round-trip update.
// ----------------------------------------------------------------------------
module swrt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                total_we,
    input  logic [15:0]         total_data,
    input  logic                load,
    input  logic                fire,
    input  swrt_pkg::mode_t     mode,
    input  logic [31:0]         sample,
    output swrt_pkg::s1_t       stage,
    output swrt_pkg::status_t   status
);

    logic [15:0] total_reg;
    logic [15:0] frag_reg, frag_next;
    logic [34:0] srtt_reg, srtt_next;
    logic        fin_reg, fin_next;
    logic        once_reg, once_next;
    logic [34:0] s8;
    logic [38:0] sum;
    logic        upd, tmo;
    swrt_pkg::action_t action;
    swrt_pkg::s1_t stage_reg;

    assign s8  = {sample, 3'b000};
    assign sum = {srtt_reg, 3'b000} - {4'd0, srtt_reg} + {4'd0, s8};

    always_comb
    begin
        frag_next = frag_reg;
        srtt_next = srtt_reg;
        fin_next  = fin_reg;
        once_next = once_reg;
        upd       = 1'b0;
        tmo       = 1'b0;
        action    = swrt_pkg::ACT_DONE;
        if (!fin_reg)
        begin
            unique case (mode)
                swrt_pkg::MODE_BAD_ACK:
                begin
                    action = swrt_pkg::ACT_ABORT;
                end
                swrt_pkg::MODE_TIMEOUT:
                begin
                    tmo       = 1'b1;
                    once_next = 1'b0;
                    action    = swrt_pkg::ACT_RESEND;
                end
                swrt_pkg::MODE_ACK_OK, swrt_pkg::MODE_ACK_REPEAT:
                begin
                    upd = once_reg && (sample != 32'd0);
                    if (upd)
                    begin
                        srtt_next = sum[37:3];
                    end
                    if (mode == swrt_pkg::MODE_ACK_OK)
                    begin
                        if (frag_reg >= total_reg)
                        begin
                            fin_next = 1'b1;
                            action   = swrt_pkg::ACT_DONE;
                        end
                        else
                        begin
                            frag_next = frag_reg + 16'd1;
                            once_next = 1'b1;
                            action    = swrt_pkg::ACT_NEXT;
                        end
                    end
                    else
                    begin
                        once_next = 1'b0;
                        action    = swrt_pkg::ACT_RESEND;
                    end
                end
                default:
                begin
                    action = swrt_pkg::ACT_ABORT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= swrt_pkg::TOTAL_RESET;
            frag_reg  <= 16'd1;
            srtt_reg  <= '0;
            fin_reg   <= 1'b0;
            once_reg  <= 1'b1;
        end
        else
        begin
            if (total_we)
            begin
                total_reg <= total_data;
            end
            if (fire)
            begin
                frag_reg <= frag_next;
                srtt_reg <= srtt_next;
                fin_reg  <= fin_next;
                once_reg <= once_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg.action <= action;
            stage_reg.frag   <= frag_next;
            stage_reg.upd    <= upd;
            stage_reg.tmo    <= tmo;
            stage_reg.s8     <= s8;
            stage_reg.srtt   <= srtt_next;
        end
    end

    assign stage           = stage_reg;
    assign status.finished = fin_reg;

endmodule

>>> sv/swrt_dev.sv
// ----------------------------------------------------------------------------
// swrt_dev
// Absolute error against the new estimate, then the deviation update.
// ----------------------------------------------------------------------------
module swrt_dev (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load_diff,
    input  logic           load_dev,
    input  logic           fire_dev,
    input  swrt_pkg::s1_t  in_stage,
    output swrt_pkg::s3_t  out_stage
);

    swrt_pkg::s2_t diff_reg;
    swrt_pkg::s3_t dev_stage_reg;
    logic [33:0]   dev_reg, dev_next;
    logic [34:0]   diff8;
    logic [36:0]   dev_sum;

    assign diff8 = (in_stage.s8 >= in_stage.srtt) ? (in_stage.s8 - in_stage.srtt)
                                                 : (in_stage.srtt - in_stage.s8);

    always_ff @(posedge clk)
    begin
        if (load_diff)
        begin
            diff_reg.action <= in_stage.action;
            diff_reg.frag   <= in_stage.frag;
            diff_reg.upd    <= in_stage.upd;
            diff_reg.tmo    <= in_stage.tmo;
            diff_reg.srtt   <= in_stage.srtt;
            diff_reg.half   <= diff8[34:1];
        end
    end

    assign dev_sum  = {1'b0, dev_reg, 1'b0} + {3'd0, dev_reg} + {3'd0, diff_reg.half};
    assign dev_next = diff_reg.upd ? dev_sum[35:2] : dev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg <= '0;
        end
        else if (fire_dev)
        begin
            dev_reg <= dev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_dev)
        begin
            dev_stage_reg.action <= diff_reg.action;
            dev_stage_reg.frag   <= diff_reg.frag;
            dev_stage_reg.upd    <= diff_reg.upd;
            dev_stage_reg.tmo    <= diff_reg.tmo;
            dev_stage_reg.srtt   <= diff_reg.srtt;
            dev_stage_reg.dev    <= dev_next;
        end
    end

    assign out_stage = dev_stage_reg;

endmodule

>>> sv/swrt_tmo.sv
// ----------------------------------------------------------------------------
// swrt_tmo
// Retransmission timeout update and the result register.
// ----------------------------------------------------------------------------
module swrt_tmo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               init_we,
    input  logic [31:0]        init_data,
    input  logic               load,
    input  logic               fire,
    input  swrt_pkg::s3_t      in_stage,
    output swrt_pkg::action_t  action,
    output logic [15:0]        fragment_number,
    output logic [31:0]        timeout_us,
    output logic [31:0]        estimated_rtt_us,
    output logic [31:0]        rtt_deviation_us
);

    logic [31:0] tmo_reg, tmo_next;
    logic [34:0] est_sum;
    logic [32:0] dbl;
    swrt_pkg::action_t action_reg;
    logic [15:0] frag_reg;
    logic [31:0] tout_reg, est_reg, dev_reg;

    assign est_sum = {3'd0, in_stage.srtt[34:3]} + {1'b0, in_stage.dev};
    assign dbl     = {tmo_reg, 1'b0};

    always_comb
    begin
        priority if (in_stage.tmo)
        begin
            tmo_next = dbl[32] ? 32'hFFFF_FFFF : dbl[31:0];
        end
        else if (in_stage.upd)
        begin
            tmo_next = (est_sum[34:32] != 3'd0) ? 32'hFFFF_FFFF : est_sum[31:0];
        end
        else
        begin
            tmo_next = tmo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmo_reg <= swrt_pkg::TIMEOUT_RESET;
        end
        else if (init_we)
        begin
            tmo_reg <= init_data;
        end
        else if (fire)
        begin
            tmo_reg <= tmo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            action_reg <= in_stage.action;
            frag_reg   <= in_stage.frag;
            tout_reg   <= tmo_next;
            est_reg    <= in_stage.srtt[34:3];
            dev_reg    <= in_stage.dev[33:2];
        end
    end

    assign action           = action_reg;
    assign fragment_number  = frag_reg;
    assign timeout_us       = tout_reg;
    assign estimated_rtt_us = est_reg;
    assign rtt_deviation_us = dev_reg;

endmodule

>>> sv/stop_wait_retransmit_timer.sv
// ----------------------------------------------------------------------------
// stop_wait_retransmit_timer
// Sender-side acknowledgement handler with an adaptive retransmission timer.
//
// Channel   Handshake             Payload
// in        in_valid, in_ready    mode, rtt_sample_us
// out       out_valid, out_ready  action, fragment_number, timeout_us,
//                                 estimated_rtt_us, rtt_deviation_us
// cfg       cfg_valid, cfg_ready  cfg_index, cfg_data
//
// One item per cycle when the output does not stall, through five
// registered steps: input, estimate, difference, deviation, and timeout
// with the result.
// Each stage holds its own valid bit, so bubbles close up under a stall.
// Reset restores the register defaults and the estimator state at once.
// Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
module stop_wait_retransmit_timer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [31:0] rtt_sample_us,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  action,
    output logic [15:0] fragment_number,
    output logic [31:0] timeout_us,
    output logic [31:0] estimated_rtt_us,
    output logic [31:0] rtt_deviation_us,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic [4:0]  v_reg;
    logic [4:0]  ld;
    logic [1:0]  mode_reg;
    logic [31:0] sample_reg;
    logic        total_we, init_we;
    swrt_pkg::s1_t     s1;
    swrt_pkg::s3_t     s3;
    swrt_pkg::status_t status;
    swrt_pkg::action_t act;

    assign ld[4] = !v_reg[4] || out_ready;
    assign ld[3] = !v_reg[3] || ld[4];
    assign ld[2] = !v_reg[2] || ld[3];
    assign ld[1] = !v_reg[1] || ld[2];
    assign ld[0] = !v_reg[0] || ld[1];

    assign in_ready  = ld[0];
    assign out_valid = v_reg[4];
    assign cfg_ready = 1'b1;
    assign total_we  = cfg_valid && (cfg_index == swrt_pkg::REG_TOTAL_FRAGMENTS);
    assign init_we   = cfg_valid && (cfg_index == swrt_pkg::REG_INITIAL_TIMEOUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0]) v_reg[0] <= in_valid;
            if (ld[1]) v_reg[1] <= v_reg[0];
            if (ld[2]) v_reg[2] <= v_reg[1];
            if (ld[3]) v_reg[3] <= v_reg[2];
            if (ld[4]) v_reg[4] <= v_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0] && in_valid)
        begin
            mode_reg   <= mode;
            sample_reg <= rtt_sample_us;
        end
    end

    swrt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .total_we   (total_we),
        .total_data (cfg_data[15:0]),
        .load       (ld[1]),
        .fire       (ld[1] && v_reg[0]),
        .mode       (swrt_pkg::mode_t'(mode_reg)),
        .sample     (sample_reg),
        .stage      (s1),
        .status     (status)
    );

    swrt_dev u_dev (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_diff (ld[2]),
        .load_dev  (ld[3]),
        .fire_dev  (ld[3] && v_reg[2]),
        .in_stage  (s1),
        .out_stage (s3)
    );

    swrt_tmo u_tmo (
        .clk              (clk),
        .rst_n            (rst_n),
        .init_we          (init_we),
        .init_data        (cfg_data),
        .load             (ld[4]),
        .fire             (ld[4] && v_reg[3]),
        .in_stage         (s3),
        .action           (act),
        .fragment_number  (fragment_number),
        .timeout_us       (timeout_us),
        .estimated_rtt_us (estimated_rtt_us),
        .rtt_deviation_us (rtt_deviation_us)
    );

    assign action = act;

`ifndef ASSERT_OFF
    a_finished_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        status.finished |=> status.finished)
        else $error("finished flag cleared after the transfer completed");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg == 5'd0) |-> in_ready)
        else $error("input not ready with an empty pipeline");

    a_next_frag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == swrt_pkg::ACT_NEXT)) |-> (fragment_number >= 16'd2))
        else $error("send-next result with the first fragment number");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable({action, fragment_number,
            timeout_us, estimated_rtt_us, rtt_deviation_us})))
        else $error("waiting result item changed or dropped");
`endif

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the stop-and-wait retransmission timer.
//
// Each accepted acknowledgement event runs through a local model of the
// timer: fragment counter, Karn-filtered RTT estimator, deviation and the
// saturating retransmission timeout. Every result item is compared field by
// field with the oldest prediction. The tests cover the reset defaults,
// field extremes, random traffic under bursty sending and a stalling
// receiver, and finally the end of the transfer.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        swrt_pkg::action_t action;
        logic [15:0]       fragment;
        logic [31:0]       timeout;
        logic [31:0]       rtt;
        logic [31:0]       deviation;
    } timer_answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = 2'd0;
    logic [31:0] rtt_sample_us = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  action;
    logic [15:0] fragment_number;
    logic [31:0] timeout_us;
    logic [31:0] estimated_rtt_us;
    logic [31:0] rtt_deviation_us;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = 32'd0;

    timer_answer_t predicted_answers[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          sink_stall_pct = 0;
    int          sink_max_run = 1;
    int unsigned sink_run = 0;

    logic [34:0] model_srtt8 = '0;
    logic [33:0] model_dev4 = '0;
    logic [31:0] model_timeout = swrt_pkg::TIMEOUT_RESET;
    logic [15:0] model_fragment = 16'd1;
    logic [15:0] model_total = swrt_pkg::TOTAL_RESET;
    bit          model_sent_once = 1'b1;
    bit          model_finished = 1'b0;

    stop_wait_retransmit_timer dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .rtt_sample_us    (rtt_sample_us),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .action           (action),
        .fragment_number  (fragment_number),
        .timeout_us       (timeout_us),
        .estimated_rtt_us (estimated_rtt_us),
        .rtt_deviation_us (rtt_deviation_us),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (sink_run != 0)
            sink_run <= sink_run - 1;
        else
        begin
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
            sink_run <= $urandom_range(sink_max_run - 1);
        end
    end

    function automatic logic [31:0] clamp_u32(input logic [63:0] value);
        return (value > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : value[31:0];
    endfunction

    function automatic void predict_answer(input swrt_pkg::mode_t kind,
                                           input logic [31:0] sample);
        logic [63:0] s8;
        logic [63:0] srtt;
        logic [63:0] diff8;
        logic [63:0] dev;
        timer_answer_t answer;
        if (model_finished)
            answer.action = swrt_pkg::ACT_DONE;
        else if (kind == swrt_pkg::MODE_BAD_ACK)
            answer.action = swrt_pkg::ACT_ABORT;
        else if (kind == swrt_pkg::MODE_TIMEOUT)
        begin
            model_timeout = clamp_u32({32'd0, model_timeout} << 1);
            model_sent_once = 1'b0;
            answer.action = swrt_pkg::ACT_RESEND;
        end
        else
        begin
            if (model_sent_once && sample != 32'd0)
            begin
                s8 = {32'd0, sample} << 3;
                srtt = (64'd7 * 64'(model_srtt8) + s8) >> 3;
                diff8 = (s8 >= srtt) ? s8 - srtt : srtt - s8;
                dev = (64'd3 * 64'(model_dev4) + (diff8 >> 1)) >> 2;
                model_srtt8 = srtt[34:0];
                model_dev4 = dev[33:0];
                model_timeout = clamp_u32((srtt >> 3) + dev);
            end
            if (kind == swrt_pkg::MODE_ACK_OK)
            begin
                if (model_fragment >= model_total)
                begin
                    model_finished = 1'b1;
                    answer.action = swrt_pkg::ACT_DONE;
                end
                else
                begin
                    model_fragment = model_fragment + 16'd1;
                    model_sent_once = 1'b1;
                    answer.action = swrt_pkg::ACT_NEXT;
                end
            end
            else
            begin
                model_sent_once = 1'b0;
                answer.action = swrt_pkg::ACT_RESEND;
            end
        end
        answer.fragment = model_fragment;
        answer.timeout = model_timeout;
        answer.rtt = model_srtt8[34:3];
        answer.deviation = model_dev4[33:2];
        predicted_answers.push_back(answer);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s differs: got 0x%0h, expected 0x%0h",
                 $realtime, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : answer_checker
        timer_answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_answers.size() == 0)
                report_mismatch("unexpected result item, action", {30'd0, action}, 32'd0);
            else
            begin
                want = predicted_answers.pop_front();
                if (action != want.action)
                    report_mismatch("action", {30'd0, action}, {30'd0, want.action});
                if (fragment_number != want.fragment)
                    report_mismatch("fragment_number", {16'd0, fragment_number},
                                    {16'd0, want.fragment});
                if (timeout_us != want.timeout)
                    report_mismatch("timeout_us", timeout_us, want.timeout);
                if (estimated_rtt_us != want.rtt)
                    report_mismatch("estimated_rtt_us", estimated_rtt_us, want.rtt);
                if (rtt_deviation_us != want.deviation)
                    report_mismatch("rtt_deviation_us", rtt_deviation_us, want.deviation);
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_event(input swrt_pkg::mode_t kind, input logic [31:0] sample);
        in_valid <= 1'b1;
        mode <= kind;
        rtt_sample_us <= sample;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_answer(kind, sample);
        @(negedge clk);
    endtask

    task automatic send_random_event();
        swrt_pkg::mode_t kind;
        logic [31:0] sample;
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            kind = swrt_pkg::MODE_ACK_OK;
        else if (pick < 72)
            kind = swrt_pkg::MODE_ACK_REPEAT;
        else if (pick < 92)
            kind = swrt_pkg::MODE_TIMEOUT;
        else
            kind = swrt_pkg::MODE_BAD_ACK;
        pick = $urandom_range(99);
        if (pick < 8)
            sample = 32'd0;
        else if (pick < 18)
            sample = $urandom;
        else if (pick < 38)
            sample = $urandom_range(1, 16);
        else
            sample = $urandom_range(1, 200000);
        send_event(kind, sample);
    endtask

    task automatic pause_until_answered();
        in_valid <= 1'b0;
        while (predicted_answers.size() != 0)
            @(negedge clk);
    endtask

    task automatic wait_for_idle();
        pause_until_answered();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_one(input logic index, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (index == swrt_pkg::REG_TOTAL_FRAGMENTS)
            model_total = data[15:0];
        else
            model_timeout = data;
        @(negedge clk);
    endtask

    task automatic program_timer(input bit set_total, input logic [31:0] total_word,
                                 input bit set_timeout, input logic [31:0] timeout_word);
        wait_for_idle();
        if (set_total)
            write_one(swrt_pkg::REG_TOTAL_FRAGMENTS, total_word);
        if (set_timeout)
            write_one(swrt_pkg::REG_INITIAL_TIMEOUT, timeout_word);
        cfg_valid <= 1'b0;
    endtask

    // With a single fragment configured, no ok ack may be sent here.
    task automatic test_reset_defaults();
        sink_stall_pct = 30;
        sink_max_run = 4;
        send_event(swrt_pkg::MODE_ACK_REPEAT, 32'd1000);
        send_event(swrt_pkg::MODE_TIMEOUT, 32'd0);
        send_event(swrt_pkg::MODE_BAD_ACK, 32'd55);
        send_event(swrt_pkg::MODE_ACK_REPEAT, 32'd0);
    endtask

    task automatic test_field_extremes();
        sink_stall_pct = 50;
        sink_max_run = 3;
        program_timer(1'b1, 32'h0000_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_event(swrt_pkg::MODE_TIMEOUT, 32'hFFFF_FFFF);
        send_event(swrt_pkg::MODE_ACK_OK, 32'hFFFF_FFFF);
        send_event(swrt_pkg::MODE_ACK_OK, 32'hFFFF_FFFF);
        send_event(swrt_pkg::MODE_ACK_OK, 32'd0);
        send_event(swrt_pkg::MODE_ACK_OK, 32'd1);
        send_event(swrt_pkg::MODE_ACK_REPEAT, 32'hFFFF_FFFF);
        send_event(swrt_pkg::MODE_ACK_REPEAT, 32'd5);
        send_event(swrt_pkg::MODE_ACK_OK, 32'd7);
        send_event(swrt_pkg::MODE_BAD_ACK, 32'hFFFF_FFFF);
        send_event(swrt_pkg::MODE_ACK_OK, 32'hFFFF_FFFF);
        send_event(swrt_pkg::MODE_TIMEOUT, 32'd0);
        send_event(swrt_pkg::MODE_TIMEOUT, 32'd0);
        send_event(swrt_pkg::MODE_ACK_OK, 32'd1);
        program_timer(1'b0, 32'd0, 1'b1, 32'd0);
        send_event(swrt_pkg::MODE_TIMEOUT, 32'd0);
        send_event(swrt_pkg::MODE_TIMEOUT, 32'd9);
        send_event(swrt_pkg::MODE_ACK_OK, 32'd0);
        send_event(swrt_pkg::MODE_ACK_OK, 32'd0);
        program_timer(1'b0, 32'd0, 1'b1, 32'd1);
        send_event(swrt_pkg::MODE_TIMEOUT, 32'd0);
        send_event(swrt_pkg::MODE_TIMEOUT, 32'd0);
        send_event(swrt_pkg::MODE_TIMEOUT, 32'd0);
    endtask

    // The total is kept well above the fragment counter so the transfer
    // stays open for the whole random part.
    task automatic test_random_traffic(input int phases, input int items_per_phase);
        logic [31:0] timeout_word;
        logic [15:0] total_low;
        int sent;
        int gap;
        int burst;
        bit paused;
        for (int p = 0; p < phases; p++)
        begin
            case ($urandom_range(4))
                0: timeout_word = 32'd0;
                1: timeout_word = 32'd1;
                2: timeout_word = 32'hFFFF_FFFF;
                3: timeout_word = $urandom;
                default: timeout_word = $urandom_range(1, 5000000);
            endcase
            total_low = 16'($urandom_range(65535, model_fragment + 400));
            sink_stall_pct = (p == 0) ? 0 : $urandom_range(80);
            sink_max_run = $urandom_range(1, 16);
            program_timer(1'b1, {16'($urandom), total_low}, 1'b1, timeout_word);
            sent = 0;
            paused = 1'b0;
            while (sent < items_per_phase)
            begin
                burst = $urandom_range(1, 40);
                for (int k = 0; k < burst && sent < items_per_phase; k++)
                begin
                    send_random_event();
                    sent++;
                end
                if (!paused && sent >= items_per_phase / 2)
                begin
                    pause_until_answered();
                    paused = 1'b1;
                end
                else if ($urandom_range(9) >= 4)
                begin
                    gap = $urandom_range(1, 8);
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
    endtask

    task automatic test_transfer_completion();
        sink_stall_pct = 40;
        sink_max_run = 6;
        program_timer(1'b1, {16'($urandom), 16'd0}, 1'b0, 32'd0);
        send_event(swrt_pkg::MODE_ACK_REPEAT, 32'd300);
        send_event(swrt_pkg::MODE_TIMEOUT, 32'd0);
        send_event(swrt_pkg::MODE_ACK_OK, 32'd250);
        repeat (20) send_random_event();
        program_timer(1'b0, 32'd0, 1'b1, $urandom);
        repeat (10) send_random_event();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_field_extremes();
        test_random_traffic(6, 230);
        test_transfer_completion();
        wait_for_idle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
sv/swrt_pkg.sv
sv/swrt_front.sv
sv/swrt_dev.sv
sv/swrt_tmo.sv
sv/stop_wait_retransmit_timer.sv
verif/tb_top.sv
